>>> src/rrc_pkg.sv
// Shared types and constants for the rotated rectangle corner block.
// No dependencies.
`default_nettype none
package rrc_pkg;
   localparam int CordicSteps = 24;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_z;
      logic signed [15:0] base_y;
      logic signed [15:0] height;
      logic signed [15:0] half_width;
      logic signed [15:0] half_depth;
      logic signed [31:0] yaw_angle;
   } item_type;

   typedef struct packed {
      logic signed [25:0] anchor_a_x;
      logic signed [25:0] anchor_a_z;
      logic signed [25:0] anchor_b_x;
      logic signed [25:0] anchor_b_z;
      logic signed [25:0] edge_a_x;
      logic signed [25:0] edge_a_z;
      logic signed [25:0] edge_b_x;
      logic signed [25:0] edge_b_z;
      logic signed [16:0] top_y;
      logic signed [15:0] bottom_y;
   } result_type;

   // queue entry: item plus its two turn phases
   typedef struct packed {
      item_type    item;
      logic [15:0] sin_phase;
      logic [15:0] cos_phase;
   } job_type;

   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
         3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
         6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
         9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
         12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
         15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
         18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
         21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
         default: t = 32'd0;
      endcase
      return t;
   endfunction
endpackage
`default_nettype wire

>>> src/rotated_rectangle_corners.sv
// Top level of the rotated rectangle corner block.
// Depends on rrc_pkg, rrc_front, rrc_queue and rrc_back.
//
//  port group | dir | beat contents
//  req_       | in  | one rectangle (tdata, 128 bits)
//  rsp_       | out | corners, edges, Y pair (tdata, 241 bits used)
//  csr_       | in  | phase scale writes (index 0 sine, 1 cosine)
//
// One beat per cycle while rsp_tready is high; beats pass the front stages,
// queue and back stages (load, one per CORDIC step, rounding, products, sums,
// Q.8 rounding, edge subtraction). Reset is synchronous and clears the valids
// and the scales to 11930465. A stalled rsp_ side fills the back pipeline, then
// the four-entry queue, then the front stages before req_tready drops.
`default_nettype none
module rotated_rectangle_corners #(
   parameter int TRIG_FRACTION_BITS = 14
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // center_x, center_z, base_y, height, half_width, half_depth, yaw_angle
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // anchor_a_x, anchor_a_z, anchor_b_x, anchor_b_z, edge_a_x, edge_a_z,
   // edge_b_x, edge_b_z, top_y, bottom_y, zero fill
   output logic [247:0]      rsp_tdata,
   input  wire logic         csr_wen,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_wdata
);
   import rrc_pkg::*;
   localparam logic CsrSin = 1'b0;
   localparam logic CsrCos = 1'b1;

   logic [31:0] sin_scale_ff, cos_scale_ff;
   item_type item;
   job_type f_job, q_job;
   result_type res;
   logic f_valid, f_ready, q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_scale_ff <= 32'd11930465;
         cos_scale_ff <= 32'd11930465;
      end else if (csr_wen) begin
         if (csr_index == CsrSin) sin_scale_ff <= csr_wdata;
         if (csr_index == CsrCos) cos_scale_ff <= csr_wdata;
      end
   end

   assign item.center_x   = req_tdata[15:0];
   assign item.center_z   = req_tdata[31:16];
   assign item.base_y     = req_tdata[47:32];
   assign item.height     = req_tdata[63:48];
   assign item.half_width = req_tdata[79:64];
   assign item.half_depth = req_tdata[95:80];
   assign item.yaw_angle  = req_tdata[127:96];

   rrc_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_item(item),
      .sin_scale(sin_scale_ff), .cos_scale(cos_scale_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job));

   rrc_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job));

   rrc_back #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res));

   assign rsp_tdata = {7'd0, res.bottom_y, res.top_y, res.edge_b_z, res.edge_b_x,
                       res.edge_a_z, res.edge_a_x, res.anchor_b_z, res.anchor_b_x,
                       res.anchor_a_z, res.anchor_a_x};

   // bottom_y passes through unchanged; top minus bottom is the height
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[247:241] == 7'd0) else $error("fill bits set");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_wen && csr_index == CsrSin |=> sin_scale_ff == $past(csr_wdata))
      else $error("sine scale write lost");
endmodule
`default_nettype wire

>>> src/rrc_front.sv
// Front end: accepts beats and forms the sine and cosine turn phases.
// Depends on rrc_pkg. Two stages: 16x32 partial products, then sum.
`default_nettype none
module rrc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire rrc_pkg::item_type in_item,
   input  wire logic [31:0]     sin_scale,
   input  wire logic [31:0]     cos_scale,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output rrc_pkg::job_type     out_job
);
   import rrc_pkg::*;
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic adv1, adv2;
   item_type s1_item_ff, s2_item_ff;
   // angle split in high signed half and low unsigned half
   logic signed [48:0] sh_ff, ch_ff;
   logic [47:0] sl_ff, cl_ff;
   logic [15:0] sp_ff, cp_ff;
   logic signed [65:0] sfull, cfull;

   assign adv2 = !s2_valid_ff || out_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_ready = adv1;
   assign s1_valid_in = adv1 ? in_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   assign sfull = {sh_ff, 16'd0} + $signed({18'd0, sl_ff});
   assign cfull = {ch_ff, 16'd0} + $signed({18'd0, cl_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (adv1) begin
         s1_item_ff <= in_item;
         sh_ff <= $signed(in_item.yaw_angle[31:16]) * $signed({1'b0, sin_scale});
         ch_ff <= $signed(in_item.yaw_angle[31:16]) * $signed({1'b0, cos_scale});
         sl_ff <= in_item.yaw_angle[15:0] * sin_scale;
         cl_ff <= in_item.yaw_angle[15:0] * cos_scale;
      end
      if (adv2) begin
         s2_item_ff <= s1_item_ff;
         sp_ff <= sfull[47:32];
         cp_ff <= cfull[47:32];
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_job.item = s2_item_ff;
   assign out_job.sin_phase = sp_ff;
   assign out_job.cos_phase = cp_ff;
endmodule
`default_nettype wire

>>> src/rrc_queue.sv
// Short queue between the front and back ends.
// Depends on rrc_pkg. Four entries in flops.
`default_nettype none
module rrc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire rrc_pkg::job_type in_job,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output rrc_pkg::job_type      out_job
);
   import rrc_pkg::*;
   job_type mem_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic push, pop;
   assign in_ready = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_job = mem_ff[rp_ff];
   assign wp_in = push ? wp_ff + 2'd1 : wp_ff;
   assign rp_in = pop ? rp_ff + 2'd1 : rp_ff;
   assign cnt_in = cnt_ff + {2'd0, push} - {2'd0, pop};
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end
endmodule
`default_nettype wire

>>> src/rrc_back.sv
// Back end: pipelined CORDIC for sine and cosine, then corner math.
// Depends on rrc_pkg. Load stage, one per CORDIC step, five finishing stages.
`default_nettype none
module rrc_back #(
   parameter int TRIG_FRACTION_BITS = 14
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire rrc_pkg::job_type in_job,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output rrc_pkg::result_type   out_result
);
   import rrc_pkg::*;
   localparam int F = TRIG_FRACTION_BITS;
   localparam int NS = CordicSteps + 1;     // pipeline stages holding CORDIC state
   localparam int NT = NS + 5;              // total stages
   localparam int PW = F + 35;              // product/coordinate width
   localparam logic signed [F+1:0] One = (F+2)'(1) <<< F;

   logic valid_ff [NT];
   logic adv [NT];
   item_type item_ff [NT];
   // CORDIC: sin unit (s) and cos unit (c)
   logic signed [33:0] sx_ff [NS], sy_ff [NS], cx_ff [NS], cy_ff [NS];
   logic signed [32:0] sz_ff [NS], cz_ff [NS];
   logic sf_ff [NS], cf_ff [NS];
   logic signed [F+1:0] sin_ff, cos_ff;
   logic signed [PW-1:0] aw_c_ff, aw_s_ff, bd_c_ff, bd_s_ff, cxo_ff, czo_ff;
   logic signed [PW-1:0] px_ff [4], pz_ff [4];
   logic signed [25:0] qx_ff [4], qz_ff [4];
   result_type res_ff;

   function automatic logic signed [F+1:0] finish(input logic signed [33:0] r, input logic fl);
      logic signed [34:0] v;
      logic signed [34:0] t;
      v = fl ? -35'(r) : 35'(r);
      t = (v + (35'sd1 <<< (29 - F))) >>> (30 - F);
      if (t > (35'sd1 <<< F)) t = 35'sd1 <<< F;
      if (t < -(35'sd1 <<< F)) t = -(35'sd1 <<< F);
      return t[F+1:0];
   endfunction

   function automatic logic signed [25:0] to_q8(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = (v + (PW'(1) <<< (F - 9))) >>> (F - 8);
      if (t > PW'(33554431)) return 26'sh1FFFFFF;
      if (t < -PW'(33554432)) return 26'sh2000000;
      return t[25:0];
   endfunction

   function automatic logic signed [25:0] sat_sub(input logic signed [25:0] a,
                                                  input logic signed [25:0] b);
      logic signed [26:0] d;
      d = 27'(a) - 27'(b);
      if (d > 27'sd33554431) return 26'sh1FFFFFF;
      if (d < -27'sd33554432) return 26'sh2000000;
      return d[25:0];
   endfunction

   function automatic logic [32:0] start_z(input logic [15:0] ph, output logic fl);
      logic [31:0] z;
      z = {ph, 16'd0};
      fl = z[31:30] == 2'd1 || z[31:30] == 2'd2;
      if (fl) z = z + 32'h80000000;
      return {z[31], z};
   endfunction

   assign adv[NT-1] = !valid_ff[NT-1] || out_ready;
   for (genvar g = NT - 2; g >= 0; g--) begin : g_adv
      assign adv[g] = !valid_ff[g] || adv[g+1];
   end
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      logic fs, fc;
      logic [32:0] zs0, zc0;
      if (reset) begin
         for (int i = 0; i < NT; i++) valid_ff[i] <= 1'b0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < NT; i++)
            if (adv[i]) valid_ff[i] <= valid_ff[i-1];
            else if (adv[i-1]) valid_ff[i] <= valid_ff[i];
      end
      zs0 = start_z(in_job.sin_phase, fs);
      zc0 = start_z(in_job.cos_phase, fc);
      if (adv[0]) begin
         item_ff[0] <= in_job.item;
         sx_ff[0] <= CordicGain; sy_ff[0] <= '0; sz_ff[0] <= zs0; sf_ff[0] <= fs;
         cx_ff[0] <= CordicGain; cy_ff[0] <= '0; cz_ff[0] <= zc0; cf_ff[0] <= fc;
      end
      for (int i = 1; i < NS; i++) begin
         if (adv[i]) begin
            item_ff[i] <= item_ff[i-1];
            sf_ff[i] <= sf_ff[i-1];
            cf_ff[i] <= cf_ff[i-1];
            if (!sz_ff[i-1][32]) begin
               sx_ff[i] <= sx_ff[i-1] - (sy_ff[i-1] >>> (i-1));
               sy_ff[i] <= sy_ff[i-1] + (sx_ff[i-1] >>> (i-1));
               sz_ff[i] <= sz_ff[i-1] - $signed({1'b0, atan_turn(i-1)});
            end else begin
               sx_ff[i] <= sx_ff[i-1] + (sy_ff[i-1] >>> (i-1));
               sy_ff[i] <= sy_ff[i-1] - (sx_ff[i-1] >>> (i-1));
               sz_ff[i] <= sz_ff[i-1] + $signed({1'b0, atan_turn(i-1)});
            end
            if (!cz_ff[i-1][32]) begin
               cx_ff[i] <= cx_ff[i-1] - (cy_ff[i-1] >>> (i-1));
               cy_ff[i] <= cy_ff[i-1] + (cx_ff[i-1] >>> (i-1));
               cz_ff[i] <= cz_ff[i-1] - $signed({1'b0, atan_turn(i-1)});
            end else begin
               cx_ff[i] <= cx_ff[i-1] + (cy_ff[i-1] >>> (i-1));
               cy_ff[i] <= cy_ff[i-1] - (cx_ff[i-1] >>> (i-1));
               cz_ff[i] <= cz_ff[i-1] + $signed({1'b0, atan_turn(i-1)});
            end
         end
      end
      // round and clamp
      if (adv[NS]) begin
         item_ff[NS] <= item_ff[NS-1];
         sin_ff <= finish(sy_ff[NS-1], sf_ff[NS-1]);
         cos_ff <= finish(cx_ff[NS-1], cf_ff[NS-1]);
      end
      // products
      if (adv[NS+1]) begin
         item_ff[NS+1] <= item_ff[NS];
         aw_c_ff <= PW'(item_ff[NS].half_width * cos_ff);
         aw_s_ff <= PW'(item_ff[NS].half_width * sin_ff);
         bd_c_ff <= PW'(item_ff[NS].half_depth * cos_ff);
         bd_s_ff <= PW'(item_ff[NS].half_depth * sin_ff);
         cxo_ff <= PW'(item_ff[NS].center_x * One);
         czo_ff <= PW'(item_ff[NS].center_z * One);
      end
      // corners: sa = +,+,-,-  sb = +,-,-,+
      if (adv[NS+2]) begin
         item_ff[NS+2] <= item_ff[NS+1];
         px_ff[0] <= cxo_ff + aw_c_ff + bd_s_ff;  pz_ff[0] <= czo_ff + bd_c_ff - aw_s_ff;
         px_ff[1] <= cxo_ff + aw_c_ff - bd_s_ff;  pz_ff[1] <= czo_ff - bd_c_ff - aw_s_ff;
         px_ff[2] <= cxo_ff - aw_c_ff - bd_s_ff;  pz_ff[2] <= czo_ff - bd_c_ff + aw_s_ff;
         px_ff[3] <= cxo_ff - aw_c_ff + bd_s_ff;  pz_ff[3] <= czo_ff + bd_c_ff + aw_s_ff;
      end
      if (adv[NS+3]) begin
         item_ff[NS+3] <= item_ff[NS+2];
         for (int k = 0; k < 4; k++) begin
            qx_ff[k] <= to_q8(px_ff[k]);
            qz_ff[k] <= to_q8(pz_ff[k]);
         end
      end
      if (adv[NS+4]) begin
         item_ff[NS+4] <= item_ff[NS+3];
         res_ff.anchor_a_x <= qx_ff[1];
         res_ff.anchor_a_z <= qz_ff[1];
         res_ff.anchor_b_x <= qx_ff[2];
         res_ff.anchor_b_z <= qz_ff[2];
         res_ff.edge_a_x <= sat_sub(qx_ff[0], qx_ff[1]);
         res_ff.edge_a_z <= sat_sub(qz_ff[0], qz_ff[1]);
         res_ff.edge_b_x <= sat_sub(qx_ff[3], qx_ff[2]);
         res_ff.edge_b_z <= sat_sub(qz_ff[3], qz_ff[2]);
         res_ff.top_y <= 17'(item_ff[NS+3].base_y) + 17'(item_ff[NS+3].height);
         res_ff.bottom_y <= item_ff[NS+3].base_y;
      end
   end

   assign out_valid = valid_ff[NT-1];
   assign out_result = res_ff;
endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking bench for rotated_rectangle_corners: drives rectangles on req_,
// checks rsp_ beats against an in-bench fixed-point model. Needs rrc_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import rrc_pkg::*;

   localparam bit CsrSinScale = 1'b0;
   localparam bit CsrCosScale = 1'b1;
   localparam logic [31:0] ResetScale = 32'd11930465;
   localparam int TrigBits = 14;
   localparam int DrainCycles = 40;      // idle wait after every result is back
   localparam int StallLimit = 5000;     // cycles with no beat before giving up
   localparam int RandomItems = 400;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [247:0] rsp_tdata;
   logic         csr_wen;
   logic         csr_index;
   logic [31:0]  csr_wdata;

   rotated_rectangle_corners DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_wen, .csr_index, .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // bench copy of the two phase scales
   logic [31:0] sin_scale, cos_scale;
   result_type  pending_results[$];
   int send_idle, recv_idle;
   int errors, accepted_items, checked_results, quiet_cycles;
   bit timed_out;

   // ---- fixed-point model -----------------------------------------------
   function automatic logic [15:0] turn_of(logic signed [31:0] angle, logic [31:0] scale);
      logic [63:0] p;
      p = 64'(longint'(angle)) * {32'd0, scale};
      return p[47:32];
   endfunction

   // sine or cosine of a 16-bit turn fraction, Q1.14, via 24-step CORDIC
   function automatic longint cordic_trig(logic [15:0] phase, bit want_sin);
      logic [31:0] z;
      bit flip;
      longint x, y, zs, dx, dy, r;
      z = {phase, 16'd0};
      flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
      if (flip) z = z + 32'h8000_0000;
      zs = longint'(signed'(z));
      x = longint'(CordicGain);
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (zs >= 0) begin
            x -= dx; y += dy; zs -= longint'(atan_turn(i));
         end else begin
            x += dx; y -= dy; zs += longint'(atan_turn(i));
         end
      end
      r = want_sin ? y : x;
      if (flip) r = -r;
      r = (r + (64'sd1 <<< (29 - TrigBits))) >>> (30 - TrigBits);
      if (r > (64'sd1 <<< TrigBits)) r = 64'sd1 <<< TrigBits;
      if (r < -(64'sd1 <<< TrigBits)) r = -(64'sd1 <<< TrigBits);
      return r;
   endfunction

   function automatic longint sat26(longint v);
      if (v > 33554431) return 33554431;
      if (v < -33554432) return -33554432;
      return v;
   endfunction

   function automatic result_type rotate_rectangle(item_type it);
      result_type res;
      longint sn, cs, one, a, b, px[4], pz[4];
      int sa[4], sb[4];
      sa = '{1, 1, -1, -1};
      sb = '{1, -1, -1, 1};
      one = 64'sd1 <<< TrigBits;
      sn = cordic_trig(turn_of(it.yaw_angle, sin_scale), 1'b1);
      cs = cordic_trig(turn_of(it.yaw_angle, cos_scale), 1'b0);
      for (int k = 0; k < 4; k++) begin
         a = sa[k] * longint'(it.half_width);
         b = sb[k] * longint'(it.half_depth);
         // exact Q.14, rounded half up to Q.8
         px[k] = sat26((longint'(it.center_x) * one + a * cs + b * sn + 32) >>> 6);
         pz[k] = sat26((longint'(it.center_z) * one + b * cs - a * sn + 32) >>> 6);
      end
      res.anchor_a_x = 26'(px[1]);
      res.anchor_a_z = 26'(pz[1]);
      res.anchor_b_x = 26'(px[2]);
      res.anchor_b_z = 26'(pz[2]);
      res.edge_a_x = 26'(sat26(px[0] - px[1]));
      res.edge_a_z = 26'(sat26(pz[0] - pz[1]));
      res.edge_b_x = 26'(sat26(px[3] - px[2]));
      res.edge_b_z = 26'(sat26(pz[3] - pz[2]));
      res.top_y = 17'(longint'(it.base_y) + longint'(it.height));
      res.bottom_y = it.base_y;
      return res;
   endfunction

   // ---- beat packing (first field lowest) --------------------------------
   function automatic logic [127:0] pack_item(item_type it);
      return {it.yaw_angle, it.half_depth, it.half_width, it.height,
              it.base_y, it.center_z, it.center_x};
   endfunction

   function automatic result_type unpack_result(logic [247:0] d);
      result_type r;
      r.anchor_a_x = d[25:0];
      r.anchor_a_z = d[51:26];
      r.anchor_b_x = d[77:52];
      r.anchor_b_z = d[103:78];
      r.edge_a_x   = d[129:104];
      r.edge_a_z   = d[155:130];
      r.edge_b_x   = d[181:156];
      r.edge_b_z   = d[207:182];
      r.top_y      = d[224:208];
      r.bottom_y   = d[240:225];
      return r;
   endfunction

   function automatic void result_fields(result_type r, output longint f[10]);
      f = '{r.anchor_a_x, r.anchor_a_z, r.anchor_b_x, r.anchor_b_z, r.edge_a_x,
            r.edge_a_z, r.edge_b_x, r.edge_b_z, r.top_y, r.bottom_y};
   endfunction

   // ---- result side: random ready, checker and watchdog ------------------
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      string names[10];
      longint got[10], want[10];
      result_type exp_r;
      names = '{"anchor_a_x", "anchor_a_z", "anchor_b_x", "anchor_b_z", "edge_a_x",
                "edge_a_z", "edge_b_x", "edge_b_z", "top_y", "bottom_y"};
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected rsp beat %h", $time, rsp_tdata);
               errors++;
            end else begin
               exp_r = pending_results.pop_front();
               result_fields(exp_r, want);
               result_fields(unpack_result(rsp_tdata), got);
               foreach (got[k])
                  if (got[k] != want[k]) begin
                     $display("%0t: %s expected %0d actual %0d", $time, names[k],
                              want[k], got[k]);
                     errors++;
                  end
               checked_results++;
            end
         end
         if (quiet_cycles > StallLimit) begin
            $display("%0t: no beat for %0d cycles", $time, StallLimit);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---- stimulus side -----------------------------------------------------
   // one beat on req_; typed expectation used when given, model otherwise
   task automatic send_rect(item_type it, bit typed, result_type typed_exp);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_item(it);
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(typed ? typed_exp : rotate_rectangle(it));
      accepted_items++;
   endtask

   // sender holds off until every beat is back, then the pipe empties
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_scale(bit index, logic [31:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (index == CsrSinScale) sin_scale = value;
      else cos_scale = value;
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(signed'($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic item_type random_rect();
      item_type it;
      it.center_x = pick16();
      it.center_z = pick16();
      it.base_y = pick16();
      it.height = pick16();
      it.half_width = pick16();
      it.half_depth = pick16();
      it.yaw_angle = ($urandom_range(7) == 0) ? {pick16(), pick16()} : $urandom;
      return it;
   endfunction

   typedef struct {
      item_type   it;
      bit         typed;
      result_type exp_r;
   } directed_row_type;

   // zero extents: corners sit on the centre, edges vanish whatever the angle
   function automatic result_type point_result(int cx, int cz, int by, int h);
      result_type r;
      r = '0;
      r.anchor_a_x = 26'(cx * 256);
      r.anchor_b_x = 26'(cx * 256);
      r.anchor_a_z = 26'(cz * 256);
      r.anchor_b_z = 26'(cz * 256);
      r.top_y = 17'(by + h);
      r.bottom_y = 16'(by);
      return r;
   endfunction

   function automatic item_type rect(int cx, int cz, int by, int h, int w, int d,
                                     logic [31:0] ang);
      item_type it;
      it = '{16'(cx), 16'(cz), 16'(by), 16'(h), 16'(w), 16'(d), ang};
      return it;
   endfunction

   initial begin
      directed_row_type rows[$];
      result_type none;
      int split[3];
      none = '0;
      errors = 0;
      accepted_items = 0;
      checked_results = 0;
      quiet_cycles = 0;
      send_idle = 14;
      recv_idle = 83;
      sin_scale = ResetScale;
      cos_scale = ResetScale;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wen = 1'b0;
      csr_index = CsrSinScale;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes of every field, wrap, mirrored extents
      rows.push_back('{rect(0, 0, 0, 0, 0, 0, 0), 1, point_result(0, 0, 0, 0)});
      rows.push_back('{rect(32767, -32768, 32767, 32767, 0, 0, 32'h7fff_ffff), 1,
                       point_result(32767, -32768, 32767, 32767)});
      rows.push_back('{rect(-32768, 32767, -32768, -32768, 0, 0, 32'h8000_0000), 1,
                       point_result(-32768, 32767, -32768, -32768)});
      rows.push_back('{rect(100, -50, 3, 7, 10, 20, 0), 0, none});
      rows.push_back('{rect(0, 0, 0, 0, 32767, 32767, 32'h005a_0000), 0, none});
      rows.push_back('{rect(0, 0, 0, 0, -32768, -32768, 32'h00b4_0000), 0, none});
      rows.push_back('{rect(32767, 32767, 0, 0, 32767, -32768, 32'h010e_0000), 0, none});
      rows.push_back('{rect(-32768, -32768, 0, 0, -32768, 32767, 32'hfff1_0000), 0, none});
      rows.push_back('{rect(5, 5, 0, 0, -40, 25, 32'h0168_0000), 0, none});   // full turn
      rows.push_back('{rect(5, 5, 0, 0, 40, -25, 32'h4000_0000), 0, none});   // wraps
      rows.push_back('{rect(-1, 1, -1, 1, 1, -1, 32'hffff_ffff), 0, none});
      rows.push_back('{rect(1234, -4321, 77, -77, 300, 200, 32'h002d_8000), 0, none});
      foreach (rows[i]) send_rect(rows[i].it, rows[i].typed, rows[i].exp_r);
      drain();

      // three idling phases, each writing its own pair of scales
      split = '{RandomItems / 3, RandomItems / 3, RandomItems - 2 * (RandomItems / 3)};
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               write_scale(CsrSinScale, 32'hffff_ffff);
               write_scale(CsrCosScale, 32'd0);
            end
            1: begin
               send_idle = 83;
               recv_idle = 14;
               write_scale(CsrSinScale, 32'd0);
               write_scale(CsrCosScale, 32'hffff_ffff);
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
               write_scale(CsrSinScale, $urandom);
               write_scale(CsrCosScale, $urandom);
            end
         endcase
         for (int n = 0; n < split[ph]; n++) begin
            send_rect(random_rect(), 0, none);
            // back to default scales midway through the first phase
            if (ph == 0 && n == split[0] / 2) begin
               drain();
               write_scale(CsrSinScale, ResetScale);
               write_scale(CsrCosScale, ResetScale);
            end
         end
         drain();
      end

      $display("Covered %0d rectangles, %0d results checked: field extremes, angle wrap,",
               accepted_items, checked_results);
      $display("mirrored extents, zero/full/random phase scales, three stall patterns.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> rotated_rectangle_corners.f
src/rrc_pkg.sv
src/rrc_front.sv
src/rrc_queue.sv
src/rrc_back.sv
src/rotated_rectangle_corners.sv
sim/testbench.sv
